@@ hw/rtl/srnh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srnh_pkg;

  // table depths
  localparam int unsigned ROUTE_DEPTH     = 128;
  localparam int unsigned NEIGHBOUR_DEPTH = 128;
  localparam int unsigned DEVICE_DEPTH    = 128;

  // the three tables share one memory, one after the other
  localparam int unsigned TOTAL_DEPTH = ROUTE_DEPTH + NEIGHBOUR_DEPTH + DEVICE_DEPTH;
  localparam int unsigned MEM_AW      = (TOTAL_DEPTH > 1) ? $clog2(TOTAL_DEPTH) : 1;
  localparam int unsigned ROUTE_BASE  = 0;
  localparam int unsigned NEIGH_BASE  = ROUTE_DEPTH;
  localparam int unsigned DEV_BASE    = ROUTE_DEPTH + NEIGHBOUR_DEPTH;

  localparam int unsigned MAX_RN    = (ROUTE_DEPTH > NEIGHBOUR_DEPTH) ? ROUTE_DEPTH
                                                                      : NEIGHBOUR_DEPTH;
  localparam int unsigned MAX_DEPTH = (MAX_RN > DEVICE_DEPTH) ? MAX_RN : DEVICE_DEPTH;
  localparam int unsigned CNT_W     = $clog2(MAX_DEPTH + 1);

  // field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned SLOT_W    = 7;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned PREFIX_W  = 24;
  localparam int unsigned PORT_W    = 8;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned HIT_W     = 7;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // widest entry: neighbour address plus mac
  localparam int unsigned MEM_W = ADDR_W + MAC_W;

  typedef enum logic [OP_W-1:0] {
    OP_WR_ROUTE = 2'd0,
    OP_WR_NEIGH = 2'd1,
    OP_WR_DEV   = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FORWARDED = 3'd0,
    ST_NO_ROUTE  = 3'd1,
    ST_NO_NEIGH  = 3'd2,
    ST_NO_DEV    = 3'd3,
    ST_LOAD_DONE = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTES  = 2'd0,
    CFG_NEIGHS  = 2'd1,
    CFG_DEVICES = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] entry_slot;
    logic [ADDR_W-1:0] address;
    logic [PORT_W-1:0] port_id;
    logic [MAC_W-1:0]  hw_address;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MAC_W-1:0]    next_hop_mac;
    logic [MAC_W-1:0]    own_mac;
    logic [PORT_W-1:0]   egress_port;
    logic [HIT_W-1:0]    route_hit;
  } out_word_t;

  // entries searched in each table
  typedef struct packed {
    logic [CNT_W-1:0] route_n;
    logic [CNT_W-1:0] neigh_n;
    logic [CNT_W-1:0] dev_n;
  } counts_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                   input int unsigned depth);
    logic [CNT_W-1:0] r;
    if (32'(v) > depth) r = CNT_W'(depth);
    else                r = CNT_W'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/srnh_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srnh_engine (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  srnh_pkg::in_word_t  item_i,
  input  srnh_pkg::counts_t   counts_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output srnh_pkg::out_word_t res_o,
  input  wire                 res_take_i
);
  import srnh_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUTE = 5'b00010,
    S_NEIGH = 5'b00100,
    S_DEV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              pend_vld_q, pend_vld_d;
  logic [CNT_W-1:0]  pend_idx_q, pend_idx_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PORT_W-1:0] egress_q, egress_d;
  logic [HIT_W-1:0]  hit_q, hit_d;
  logic [MAC_W-1:0]  next_mac_q, next_mac_d;
  out_word_t         res_q, res_d;

  // shared table memory
  logic [MEM_W-1:0]  mem_q [TOTAL_DEPTH];
  logic [MEM_W-1:0]  rd_data_q;
  logic              mem_re, mem_we;
  logic [MEM_AW-1:0] mem_raddr, mem_waddr;
  logic [MEM_W-1:0]  mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  logic             cur_match;
  logic [CNT_W-1:0] cur_n;
  logic [MEM_AW-1:0] cur_base;
  logic             scan_hit;

  always_comb begin
    cur_match = 1'b0;
    cur_n     = '0;
    cur_base  = '0;
    unique case (state_q)
      S_ROUTE: begin
        cur_match = rd_data_q[PREFIX_W+PORT_W-1:PORT_W] == addr_q[ADDR_W-1:ADDR_W-PREFIX_W];
        cur_n     = counts_i.route_n;
        cur_base  = MEM_AW'(ROUTE_BASE);
      end
      S_NEIGH: begin
        cur_match = rd_data_q[MAC_W+ADDR_W-1:MAC_W] == addr_q;
        cur_n     = counts_i.neigh_n;
        cur_base  = MEM_AW'(NEIGH_BASE);
      end
      S_DEV: begin
        cur_match = rd_data_q[MAC_W+PORT_W-1:MAC_W] == egress_q;
        cur_n     = counts_i.dev_n;
        cur_base  = MEM_AW'(DEV_BASE);
      end
      default: begin
        cur_match = 1'b0;
      end
    endcase
  end

  assign scan_hit = pend_vld_q & cur_match;

  always_comb begin
    state_d    = state_q;
    issue_d    = issue_q;
    pend_vld_d = 1'b0;
    pend_idx_d = pend_idx_q;
    addr_d     = addr_q;
    egress_d   = egress_q;
    hit_d      = hit_q;
    next_mac_d = next_mac_q;
    res_d      = res_q;
    mem_re     = 1'b0;
    mem_raddr  = cur_base + MEM_AW'(issue_q);
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d        = '0;
          res_d.status = ST_LOAD_DONE;
          state_d      = S_DONE;
          unique case (op_e'(item_i.op))
            OP_WR_ROUTE: begin
              mem_we    = 32'(item_i.entry_slot) < ROUTE_DEPTH;
              mem_waddr = MEM_AW'(ROUTE_BASE) + MEM_AW'(item_i.entry_slot);
              mem_wdata = MEM_W'({item_i.address[ADDR_W-1:ADDR_W-PREFIX_W], item_i.port_id});
            end
            OP_WR_NEIGH: begin
              mem_we    = 32'(item_i.entry_slot) < NEIGHBOUR_DEPTH;
              mem_waddr = MEM_AW'(NEIGH_BASE) + MEM_AW'(item_i.entry_slot);
              mem_wdata = MEM_W'({item_i.address, item_i.hw_address});
            end
            OP_WR_DEV: begin
              mem_we    = 32'(item_i.entry_slot) < DEVICE_DEPTH;
              mem_waddr = MEM_AW'(DEV_BASE) + MEM_AW'(item_i.entry_slot);
              mem_wdata = MEM_W'({item_i.port_id, item_i.hw_address});
            end
            OP_LOOKUP: begin
              addr_d  = item_i.address;
              issue_d = '0;
              state_d = S_ROUTE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_ROUTE, S_NEIGH, S_DEV: begin
        if (scan_hit) begin
          issue_d = '0;
          if (state_q == S_ROUTE) begin
            egress_d = rd_data_q[PORT_W-1:0];
            hit_d    = HIT_W'(pend_idx_q);
            state_d  = S_NEIGH;
          end else if (state_q == S_NEIGH) begin
            next_mac_d = rd_data_q[MAC_W-1:0];
            state_d    = S_DEV;
          end else begin
            res_d.status       = ST_FORWARDED;
            res_d.next_hop_mac = next_mac_q;
            res_d.own_mac      = rd_data_q[MAC_W-1:0];
            res_d.egress_port  = egress_q;
            res_d.route_hit    = hit_q;
            state_d            = S_DONE;
          end
        end else if (issue_q == cur_n) begin
          // table exhausted without a match
          res_d   = '0;
          state_d = S_DONE;
          if (state_q == S_ROUTE) begin
            res_d.status = ST_NO_ROUTE;
          end else if (state_q == S_NEIGH) begin
            res_d.status      = ST_NO_NEIGH;
            res_d.egress_port = egress_q;
            res_d.route_hit   = hit_q;
          end else begin
            res_d.status       = ST_NO_DEV;
            res_d.next_hop_mac = next_mac_q;
            res_d.egress_port  = egress_q;
            res_d.route_hit    = hit_q;
          end
        end else begin
          mem_re     = 1'b1;
          issue_d    = issue_q + 1'b1;
          pend_vld_d = 1'b1;
          pend_idx_d = issue_q;
        end
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      issue_q    <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    addr_q     <= addr_d;
    egress_q   <= egress_d;
    hit_q      <= hit_d;
    next_mac_q <= next_mac_d;
    res_q      <= res_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/static_route_next_hop_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none

// static route and next-hop lookup. load words write one slot of the route, neighbour or
// device table and answer with status load done; a lookup word scans the route table for
// the first prefix equal to the top 24 address bits, then the neighbour table for the full
// address, then the device table for the route's egress port, and answers with both macs
// or the status of the first table that missed. all three tables live in one memory with
// separate read and write ports and a registered read, scanned one entry per cycle. one
// word is in work at a time; the next word is taken as soon as the result has moved into
// the output register, even while that register is still stalled. table contents are
// undefined until written, and the in-use registers may only be written while no word is
// in work

module static_route_next_hop_lookup (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // input words
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  srnh_pkg::in_word_t                    in_word_i,
  // result words
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output srnh_pkg::out_word_t                   out_word_o,
  // register writes
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire [srnh_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [srnh_pkg::CFG_W-1:0]             cfg_data_i
);
  import srnh_pkg::*;

  // in-use registers
  logic [CFG_W-1:0] routes_q, neighs_q, devices_q;
  counts_t          counts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      routes_q  <= '0;
      neighs_q  <= '0;
      devices_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROUTES:  routes_q  <= cfg_data_i;
        CFG_NEIGHS:  neighs_q  <= cfg_data_i;
        CFG_DEVICES: devices_q <= cfg_data_i;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // counts beyond the table depth search the whole table
  always_comb begin
    counts.route_n = clamp_count(routes_q, ROUTE_DEPTH);
    counts.neigh_n = clamp_count(neighs_q, NEIGHBOUR_DEPTH);
    counts.dev_n   = clamp_count(devices_q, DEVICE_DEPTH);
  end

  // lookup engine with the table memory
  logic      eng_busy;
  logic      eng_res_valid;
  out_word_t eng_res;
  logic      eng_take;
  logic      in_accept;

  assign in_stall_o = eng_busy;
  assign in_accept  = in_valid_i & ~eng_busy;

  srnh_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .item_i      (in_word_i),
    .counts_i    (counts),
    .busy_o      (eng_busy),
    .res_valid_o (eng_res_valid),
    .res_o       (eng_res),
    .res_take_i  (eng_take)
  );

  // output register parts the engine from the result stall
  logic      out_valid_q;
  out_word_t out_word_q;

  assign eng_take = eng_res_valid & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_take) begin
      out_word_q <= eng_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a load word is answered by the engine on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_word_i.op != OP_LOOKUP) |=>
      (eng_res_valid && eng_res.status == ST_LOAD_DONE))
    else $error("load word not answered with load done");

  // a route miss carries nothing but its status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == ST_NO_ROUTE) |->
      (out_word_o.next_hop_mac == '0 && out_word_o.own_mac == '0 &&
       out_word_o.egress_port == '0 && out_word_o.route_hit == '0))
    else $error("route miss with non-zero fields");

  // once a word is taken the block stays busy until its result is handed over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("new word taken while one is in work");

endmodule

`default_nettype wire
